// ===== rtl/crs_pkg.sv =====
package crs_pkg;

    localparam int MAX_STOPS_DEF = 16;

    localparam logic [16:0] POS_ONE   = 17'h10000;
    localparam logic [12:0] RES_RESET = 13'd256;

    // Divider geometry: widest dividend is sample_index << 16 (28 bits),
    // widest divisor is a stop span of up to 1.0 (17 bits).
    localparam int DIV_NUM_W  = 28;
    localparam int DIV_DEN_W  = 17;
    localparam int DIV_STEP_W = 4;

    // Two quotient bits per step.
    localparam logic [DIV_STEP_W-1:0] FAC_STEPS = 4'd14;
    localparam logic [DIV_STEP_W-1:0] T_STEPS   = 4'd9;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } crs_op_t;

    localparam logic REG_RESOLUTION = 1'b0;
    localparam logic REG_STOP_COUNT = 1'b1;

    typedef struct packed
    {
        crs_op_t     opcode;
        logic [3:0]  stop_slot;
        logic [16:0] stop_position;
        logic [15:0] stop_red;
        logic [15:0] stop_green;
        logic [15:0] stop_blue;
        logic [11:0] sample_index;
    } crs_cmd_t;

    typedef struct packed
    {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        found;
    } crs_rsp_t;

    typedef struct packed
    {
        logic [16:0] pos;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } crs_stop_t;

    typedef struct packed
    {
        logic                  start;
        logic [DIV_DEN_W-1:0]  rem;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_STEP_W-1:0] steps;
    } crs_div_req_t;

    typedef struct packed
    {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } crs_div_rsp_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FAC,
        ST_SEARCH,
        ST_TDIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } crs_state_t;

endpackage

// ===== rtl/crs_stream_if.sv =====
interface crs_stream_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== rtl/crs_div.sv =====
// Restoring divider, two quotient bits per cycle. The caller preloads the
// partial remainder so that only the quotient bits that can be set are run.
module crs_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  crs_pkg::crs_div_req_t req,
    output crs_pkg::crs_div_rsp_t rsp
);

    localparam int NW = crs_pkg::DIV_NUM_W;
    localparam int DW = crs_pkg::DIV_DEN_W;
    localparam int SW = crs_pkg::DIV_STEP_W;

    logic [DW-1:0] rem_reg,  rem_next;
    logic [NW-1:0] num_reg,  num_next;
    logic [NW-1:0] quot_reg, quot_next;
    logic [DW-1:0] den_reg,  den_next;
    logic [SW-1:0] cnt_reg,  cnt_next;
    logic          done_reg, done_next;

    logic [DW:0]   r1, r2;
    logic          ge1, ge2;
    logic [DW-1:0] s1, s2;

    always_comb
    begin
        r1  = {rem_reg, num_reg[NW-1]};
        ge1 = r1 >= {1'b0, den_reg};
        s1  = ge1 ? DW'(r1 - {1'b0, den_reg}) : r1[DW-1:0];
        r2  = {s1, num_reg[NW-2]};
        ge2 = r2 >= {1'b0, den_reg};
        s2  = ge2 ? DW'(r2 - {1'b0, den_reg}) : r2[DW-1:0];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.rem;
            num_next  = req.num;
            den_next  = req.den;
            cnt_next  = req.steps;
            quot_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = s2;
            num_next  = {num_reg[NW-3:0], 2'b00};
            quot_next = {quot_reg[NW-3:0], ge1, ge2};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == SW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== rtl/color_ramp_sampler_core.sv =====
// Piecewise linear color ramp sampler.
// cmd channel: a load beat writes one color stop (position saturated to 1.0)
// into the stop memory and gives no result; a lookup beat gives one rsp beat.
// rsp channel: the sampled color and a found flag (black, found low, when no
// stop at or above the sample position lies among the first stop_count).
// APB port: resolution at 0x0, stop_count at 0x4; write only while idle.
// A lookup runs the position division (two quotient bits per cycle), then
// scans the stops up to the matching one (one memory read per cycle), then
// divides for the blend fraction and makes the three channel blends (one
// multiplier, shared); a hit on stop 0 or a miss skips the blend. One item
// is in work at a time; loads go straight into the stop memory. The divider
// serves both divisions and the stop memory has a single read port.
// Reset leaves resolution at 256, stop_count at 0 and the stop memory
// unwritten. A finished result sits in the output register; the next item
// is accepted while it waits. When the receiver stalls and the output
// register is still full, the following result holds in the core and no
// new beat is taken until the register frees up.
module color_ramp_sampler_core #(
    parameter int MAX_STOPS = crs_pkg::MAX_STOPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    crs_stream_if.sink   cmd,
    crs_stream_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW = $clog2(MAX_STOPS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] resolution_reg;
    logic [4:0]  stop_count_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= crs_pkg::RES_RESET;
            stop_count_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                crs_pkg::REG_RESOLUTION: resolution_reg <= pwdata[12:0];
                crs_pkg::REG_STOP_COUNT: stop_count_reg <= pwdata[4:0];
                default:                 stop_count_reg <= stop_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            crs_pkg::REG_RESOLUTION: prdata = {19'b0, resolution_reg};
            crs_pkg::REG_STOP_COUNT: prdata = {27'b0, stop_count_reg};
            default:                 prdata = '0;
        endcase
    end

    // Zero resolution divides as one; stop count clips to the table size.
    logic [16:0]   res_eff;
    logic [CW-1:0] n_eff;

    assign res_eff = (resolution_reg == '0) ? 17'd1 : {4'b0, resolution_reg};
    assign n_eff   = (int'(stop_count_reg) > MAX_STOPS) ? CW'(MAX_STOPS)
                                                        : CW'(stop_count_reg);

    // ------------------------------------------------------------------
    // Stop memory: one write port (loads), one registered read port (scan)
    // ------------------------------------------------------------------
    crs_pkg::crs_stop_t stop_mem [MAX_STOPS];
    crs_pkg::crs_stop_t rd_data_reg;
    crs_pkg::crs_stop_t wr_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic cmd_fire;
    logic rsp_fire;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign rsp_fire = rsp.valid && rsp.ready;

    always_comb
    begin
        wr_en         = cmd_fire && (cmd.data.opcode == crs_pkg::OP_LOAD) &&
                        (int'(cmd.data.stop_slot) < MAX_STOPS);
        wr_addr       = AW'(cmd.data.stop_slot);
        wr_data.pos   = (cmd.data.stop_position > crs_pkg::POS_ONE) ? crs_pkg::POS_ONE
                                                                    : cmd.data.stop_position;
        wr_data.red   = cmd.data.stop_red;
        wr_data.green = cmd.data.stop_green;
        wr_data.blue  = cmd.data.stop_blue;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stop_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= stop_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Shared divider: position fraction, then blend fraction
    // ------------------------------------------------------------------
    crs_pkg::crs_div_req_t div_req;
    crs_pkg::crs_div_rsp_t div_rsp;

    crs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    crs_pkg::crs_state_t state_reg, state_next;
    logic [27:0]         fac_reg,   fac_next;
    logic [CW-1:0]       ridx_reg,  ridx_next;
    logic [AW-1:0]       cidx_reg,  cidx_next;
    logic                vld_reg,   vld_next;
    crs_pkg::crs_stop_t  prev_reg,  prev_next;
    crs_pkg::crs_stop_t  cur_reg,   cur_next;
    logic [16:0]         t_reg,     t_next;
    logic [1:0]          ch_reg,    ch_next;
    logic signed [34:0]  prod_reg,  prod_next;
    crs_pkg::crs_rsp_t   res_reg,   res_next;
    crs_pkg::crs_rsp_t   out_reg,   out_next;
    logic                out_vld_reg, out_vld_next;

    logic               hit;
    logic               issue;
    logic [16:0]        span_diff;
    logic [16:0]        span_den;
    logic [15:0]        a_ch;
    logic [15:0]        b_ch;
    logic signed [16:0] ch_diff;
    logic signed [35:0] blend_sum;

    assign hit   = vld_reg && ({11'b0, rd_data_reg.pos} >= fac_reg);
    assign issue = (ridx_reg < n_eff) && !hit;

    // prev < fac <= cur, so the span is never zero and t lands in (0, 1.0]
    assign span_diff = fac_reg[16:0] - prev_reg.pos;
    assign span_den  = rd_data_reg.pos - prev_reg.pos;

    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                a_ch = prev_reg.red;
                b_ch = cur_reg.red;
            end
            2'd1:
            begin
                a_ch = prev_reg.green;
                b_ch = cur_reg.green;
            end
            default:
            begin
                a_ch = prev_reg.blue;
                b_ch = cur_reg.blue;
            end
        endcase
    end

    // a*(1-t) + b*t  ==  a + (b-a)*t, with round to nearest
    assign ch_diff   = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
    assign blend_sum = $signed({4'b0, a_ch, 16'h8000}) + 36'(prod_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crs_pkg::ST_IDLE:
            begin
                if (cmd_fire && (cmd.data.opcode == crs_pkg::OP_LOOKUP))
                begin
                    state_next = crs_pkg::ST_FAC;
                end
            end
            crs_pkg::ST_FAC:
            begin
                if (div_rsp.done)
                begin
                    state_next = crs_pkg::ST_SEARCH;
                end
            end
            crs_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    state_next = (cidx_reg == '0) ? crs_pkg::ST_DONE : crs_pkg::ST_TDIV;
                end
                else if (!vld_reg && !issue)
                begin
                    state_next = crs_pkg::ST_DONE;
                end
            end
            crs_pkg::ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = crs_pkg::ST_MUL;
                end
            end
            crs_pkg::ST_MUL:
            begin
                state_next = crs_pkg::ST_ADD;
            end
            crs_pkg::ST_ADD:
            begin
                state_next = (ch_reg == 2'd2) ? crs_pkg::ST_DONE : crs_pkg::ST_MUL;
            end
            crs_pkg::ST_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    state_next = crs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        fac_next     = fac_reg;
        ridx_next    = ridx_reg;
        cidx_next    = cidx_reg;
        vld_next     = vld_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        t_next       = t_reg;
        ch_next      = ch_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        rd_en        = 1'b0;
        rd_addr      = ridx_reg[AW-1:0];
        div_req      = '0;

        // Drop the held result once the receiver takes it
        if (rsp_fire)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            crs_pkg::ST_IDLE:
            begin
                if (cmd_fire && (cmd.data.opcode == crs_pkg::OP_LOOKUP))
                begin
                    div_req.start = 1'b1;
                    div_req.rem   = '0;
                    div_req.num   = {cmd.data.sample_index, 16'b0};
                    div_req.den   = res_eff;
                    div_req.steps = crs_pkg::FAC_STEPS;
                end
            end
            crs_pkg::ST_FAC:
            begin
                if (div_rsp.done)
                begin
                    fac_next  = div_rsp.quot;
                    ridx_next = '0;
                    vld_next  = 1'b0;
                end
            end
            crs_pkg::ST_SEARCH:
            begin
                // Advance the read pointer one stop per cycle until a hit or the last counted stop
                vld_next = issue;
                if (issue)
                begin
                    rd_en     = 1'b1;
                    cidx_next = ridx_reg[AW-1:0];
                    ridx_next = ridx_reg + 1'b1;
                end
                if (vld_reg && !hit)
                begin
                    prev_next = rd_data_reg;
                end
                if (hit)
                begin
                    if (cidx_reg == '0)
                    begin
                        res_next.red_out   = rd_data_reg.red;
                        res_next.green_out = rd_data_reg.green;
                        res_next.blue_out  = rd_data_reg.blue;
                        res_next.found     = 1'b1;
                    end
                    else
                    begin
                        cur_next      = rd_data_reg;
                        div_req.start = 1'b1;
                        div_req.rem   = {2'b0, span_diff[16:2]};
                        div_req.num   = {span_diff[1:0], 26'b0};
                        div_req.den   = span_den;
                        div_req.steps = crs_pkg::T_STEPS;
                    end
                end
                else if (!vld_reg && !issue)
                begin
                    res_next = '0;
                end
            end
            crs_pkg::ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    t_next  = div_rsp.quot[16:0];
                    ch_next = 2'd0;
                end
            end
            crs_pkg::ST_MUL:
            begin
                prod_next = ch_diff * $signed({1'b0, t_reg});
            end
            crs_pkg::ST_ADD:
            begin
                case (ch_reg)
                    2'd0:    res_next.red_out   = blend_sum[31:16];
                    2'd1:    res_next.green_out = blend_sum[31:16];
                    default: res_next.blue_out  = blend_sum[31:16];
                endcase
                res_next.found = 1'b1;
                ch_next        = ch_reg + 1'b1;
            end
            crs_pkg::ST_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crs_pkg::ST_IDLE;
            vld_reg     <= 1'b0;
            ridx_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            ridx_reg    <= ridx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fac_reg  <= fac_next;
        cidx_reg <= cidx_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        t_reg    <= t_next;
        ch_reg   <= ch_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign cmd.ready = (state_reg == crs_pkg::ST_IDLE);
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

endmodule

// ===== verif/color_ramp_sampler_core_tb.sv =====
`timescale 1ns / 100ps

module color_ramp_sampler_core_tb;

    localparam int LIMIT_CYCLES  = 500000;
    // Margin past the worst lookup.
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 16;

    // Track the ramp table and registers, and keep the colors still owed by the block.
    class ramp_scoreboard;
        logic [12:0]        resolution;
        logic [4:0]         stop_count;
        crs_pkg::crs_stop_t stops [crs_pkg::MAX_STOPS_DEF];
        crs_pkg::crs_rsp_t  expected_colors [$];
        int                 mismatches;

        function new();
            resolution = crs_pkg::RES_RESET;
            stop_count = '0;
            mismatches = 0;
            foreach (stops[i])
                stops[i] = '0;
        endfunction

        function void write_reg(input logic reg_idx, input logic [31:0] value);
            if (reg_idx == crs_pkg::REG_RESOLUTION)
                resolution = value[12:0];
            else
                stop_count = value[4:0];
        endfunction

        function logic [15:0] mix_channel(input logic [15:0] a, input logic [15:0] b,
                                          input logic [63:0] t);
            logic [63:0] v;
            v = 64'(a) * (64'(crs_pkg::POS_ONE) - t) + 64'(b) * t + 64'd32768;
            return v[31:16];
        endfunction

        function crs_pkg::crs_rsp_t sample_ramp(input logic [11:0] idx);
            crs_pkg::crs_rsp_t r;
            logic [63:0]       res;
            logic [63:0]       fac;
            logic [63:0]       den;
            logic [63:0]       t;
            int                n;
            bit                hit;
            r   = '0;
            hit = 1'b0;
            res = (resolution == 0) ? 64'd1 : 64'(resolution);
            fac = (64'(idx) << 16) / res;
            n   = (stop_count > crs_pkg::MAX_STOPS_DEF) ? crs_pkg::MAX_STOPS_DEF
                                                        : int'(stop_count);
            for (int j = 0; j < n && !hit; j++)
            begin
                if (64'(stops[j].pos) >= fac)
                begin
                    hit = 1'b1;
                    if (j == 0)
                    begin
                        r.red_out   = stops[0].red;
                        r.green_out = stops[0].green;
                        r.blue_out  = stops[0].blue;
                    end
                    else
                    begin
                        // Previous stop failed the test, so it lies below fac.
                        den = 64'(stops[j].pos) - 64'(stops[j-1].pos);
                        t   = (den == 0) ? 64'(crs_pkg::POS_ONE)
                                         : ((fac - 64'(stops[j-1].pos)) << 16) / den;
                        if (t > 64'(crs_pkg::POS_ONE))
                            t = 64'(crs_pkg::POS_ONE);
                        r.red_out   = mix_channel(stops[j-1].red,   stops[j].red,   t);
                        r.green_out = mix_channel(stops[j-1].green, stops[j].green, t);
                        r.blue_out  = mix_channel(stops[j-1].blue,  stops[j].blue,  t);
                    end
                    r.found = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_cmd(input crs_pkg::crs_cmd_t c);
            if (c.opcode == crs_pkg::OP_LOAD)
            begin
                stops[c.stop_slot].pos   = (c.stop_position > crs_pkg::POS_ONE)
                                           ? crs_pkg::POS_ONE : c.stop_position;
                stops[c.stop_slot].red   = c.stop_red;
                stops[c.stop_slot].green = c.stop_green;
                stops[c.stop_slot].blue  = c.stop_blue;
            end
            else
                expected_colors = {expected_colors, sample_ramp(c.sample_index)};
        endfunction

        function void check_rsp(input crs_pkg::crs_rsp_t got);
            crs_pkg::crs_rsp_t want;
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: r=%h g=%h b=%h found=%b",
                             got.red_out, got.green_out, got.blue_out, got.found);
                return;
            end
            want = expected_colors.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.found !== want.found)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp r=%h g=%h b=%h f=%b, got r=%h g=%h b=%h f=%b",
                             want.red_out, want.green_out, want.blue_out, want.found,
                             got.red_out, got.green_out, got.blue_out, got.found);
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Idling switch shared by both sides; cleared for a long clean stretch.
    bit             idle_on;
    // Long receiver hold-off, requested by the sequence, served by the receiver.
    int             hold_req;
    ramp_scoreboard ramp_sb;

    crs_stream_if #(.data_t(crs_pkg::crs_cmd_t)) cmd_if ();
    crs_stream_if #(.data_t(crs_pkg::crs_rsp_t)) rsp_if ();

    color_ramp_sampler_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Receiver: check each accepted result beat, then pick ready for the next cycle.
    // Signals are read right after the edge, before any update of this step lands.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                ramp_sb.check_rsp(rsp_if.data);
            if (hold_left == 0 && hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Fill every field with random bits; callers then shape the ones that matter.
    function automatic crs_pkg::crs_cmd_t random_cmd(input crs_pkg::crs_op_t op);
        crs_pkg::crs_cmd_t c;
        c.opcode        = op;
        c.stop_slot     = 4'($urandom);
        c.stop_position = 17'($urandom);
        c.stop_red      = 16'($urandom);
        c.stop_green    = 16'($urandom);
        c.stop_blue     = 16'($urandom);
        c.sample_index  = 12'($urandom);
        return c;
    endfunction

    // Offer one command beat and hold it until the block takes it.
    // Leave valid high afterwards so back-to-back beats need no extra cycle.
    task automatic send_cmd(input crs_pkg::crs_cmd_t c);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        ramp_sb.note_cmd(c);
    endtask

    // Drop valid, wait for every owed result, then let a trailing load finish.
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (ramp_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ramp_sb.write_reg(reg_idx, value);
    endtask

    // Load slots 0..n-1 with rising positions (or random ones when shuffled).
    // Raw positions may run past 1.0 and get saturated by the block.
    task automatic load_ramp(input int n, input bit shuffle);
        crs_pkg::crs_cmd_t c;
        int                pos;
        pos = $urandom_range(0, 2048);
        for (int s = 0; s < n; s++)
        begin
            c = random_cmd(crs_pkg::OP_LOAD);
            c.stop_slot = 4'(s);
            if (!shuffle)
            begin
                c.stop_position = (pos > 131071) ? 17'h1FFFF : pos[16:0];
                pos += $urandom_range(1, 131072 / n);
            end
            send_cmd(c);
        end
    endtask

    // One phase: settle, program both registers, load a ramp, then mostly lookups
    // with a sprinkle of stray loads that break the ordering.
    task automatic run_phase(input int res, input int count, input int beats,
                             input bit shuffle, input bit hold);
        crs_pkg::crs_cmd_t c;
        int                span;
        int                top;
        settle();
        apb_write(crs_pkg::REG_RESOLUTION, res);
        apb_write(crs_pkg::REG_STOP_COUNT, count);
        load_ramp((count > crs_pkg::MAX_STOPS_DEF) ? crs_pkg::MAX_STOPS_DEF : count,
                  shuffle);
        if (hold)
            hold_req = 400;
        span = (res == 0) ? 1 : res;
        top  = (span > 4095) ? 4095 : span;
        repeat (beats)
        begin
            if ($urandom_range(0, 99) < 12)
                c = random_cmd(crs_pkg::OP_LOAD);
            else
            begin
                c = random_cmd(crs_pkg::OP_LOOKUP);
                // Keep most samples inside the ramp; the rest take any index and may run past 1.0.
                if ($urandom_range(0, 99) < 80)
                    c.sample_index = 12'($urandom_range(0, top));
            end
            send_cmd(c);
        end
    endtask

    initial
    begin
        crs_pkg::crs_cmd_t c;
        ramp_sb  = new();
        idle_on  = 1'b1;
        hold_req = 0;

        rst_n        <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ramp: stop_count is 0 after reset, so lookups read no slot.
        c = random_cmd(crs_pkg::OP_LOOKUP);
        c.sample_index = 12'd0;
        send_cmd(c);
        c = random_cmd(crs_pkg::OP_LOOKUP);
        c.sample_index = 12'hFFF;
        send_cmd(c);

        // Write every slot once, extreme colors, even positions, last one past 1.0.
        for (int s = 0; s < crs_pkg::MAX_STOPS_DEF; s++)
        begin
            c = random_cmd(crs_pkg::OP_LOAD);
            c.stop_slot     = 4'(s);
            c.stop_position = (s == crs_pkg::MAX_STOPS_DEF - 1) ? 17'h1FFFF
                                                                : 17'(s * 4369);
            c.stop_red      = s[0] ? 16'hFFFF : 16'h0000;
            c.stop_green    = ~c.stop_red;
            c.stop_blue     = 16'(s * 4369);
            send_cmd(c);
        end

        // Stop 0 hit, mid blends, exactly 1.0 and far past the end.
        settle();
        apb_write(crs_pkg::REG_STOP_COUNT, crs_pkg::MAX_STOPS_DEF);
        c = random_cmd(crs_pkg::OP_LOOKUP); c.sample_index = 12'd0;   send_cmd(c);
        c = random_cmd(crs_pkg::OP_LOOKUP); c.sample_index = 12'd128; send_cmd(c);
        c = random_cmd(crs_pkg::OP_LOOKUP); c.sample_index = 12'd255; send_cmd(c);
        c = random_cmd(crs_pkg::OP_LOOKUP); c.sample_index = 12'd256; send_cmd(c);
        c = random_cmd(crs_pkg::OP_LOOKUP); c.sample_index = 12'hFFF; send_cmd(c);

        run_phase(256, 16, 42, 1'b0, 1'b0);
        run_phase(1, 1, 42, 1'b0, 1'b0);
        // Long clean stretch: neither side idles.
        idle_on = 1'b0;
        run_phase(4096, 16, 42, 1'b0, 1'b0);
        idle_on = 1'b1;
        // Stop count past the table saturates; widest resolution.
        run_phase(8191, 31, 42, 1'b0, 1'b0);
        // Zero resolution acts as 1; receiver holds off so the block backs up.
        run_phase(0, 16, 42, 1'b0, 1'b1);
        run_phase($urandom_range(1, 4096), $urandom_range(0, 16), 42, 1'b1, 1'b0);
        run_phase(3, 2, 42, 1'b0, 1'b0);
        run_phase($urandom_range(1, 4096), 0, 42, 1'b0, 1'b0);
        run_phase($urandom_range(1, 8191), $urandom_range(2, 16), 42, 1'b0, 1'b0);
        run_phase(100, 16, 42, 1'b1, 1'b0);

        settle();
        if (ramp_sb.mismatches == 0 && ramp_sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== color_ramp_sampler_core.f =====
rtl/crs_pkg.sv
rtl/crs_stream_if.sv
rtl/crs_div.sv
rtl/color_ramp_sampler_core.sv
verif/color_ramp_sampler_core_tb.sv
